>>> src/bounded_deque_engine_top_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the bounded deque engine
// Concurrent property wrappers, compiled out when SYNTH is set.
// ---------------------------------------------------------------------------
`ifndef BOUNDED_DEQUE_ENGINE_TOP_DEFINES_SVH
`define BOUNDED_DEQUE_ENGINE_TOP_DEFINES_SVH
`ifndef SYNTH
`define BDQ_ASSERT_ALWAYS(lbl, expr) \
   lbl: assert property (@(posedge clock) disable iff (reset) (expr)) \
      else $error("assertion failed");
`define BDQ_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");
`define BDQ_ASSERT_SAME(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");
`else
`define BDQ_ASSERT_ALWAYS(lbl, expr)
`define BDQ_ASSERT_NEXT(lbl, ante, cons)
`define BDQ_ASSERT_SAME(lbl, ante, cons)
`endif
`endif

>>> src/bdq_pkg.sv
// ---------------------------------------------------------------------------
// bdq_pkg
// Types and constants shared by the bounded deque engine.
// ---------------------------------------------------------------------------
package bdq_pkg;

   localparam int DEPTH_DEFAULT = 16;
   localparam int VAL_W         = 32;
   localparam int POS_W         = 5;
   localparam int CNT_OUT_W     = 5;

   typedef enum logic [2:0] {
      ACT_PUSH_FRONT = 3'd0,
      ACT_PUSH_BACK  = 3'd1,
      ACT_POP_FRONT  = 3'd2,
      ACT_POP_BACK   = 3'd3,
      ACT_INSERT     = 3'd4,
      ACT_DEDUPE     = 3'd5,
      ACT_QUERY      = 3'd6
   } act_type;

   typedef enum logic [1:0] {
      ERR_OK    = 2'd0,
      ERR_FULL  = 2'd1,
      ERR_EMPTY = 2'd2,
      ERR_POS   = 2'd3
   } err_type;

   typedef enum logic [2:0] {
      OP_NONE,
      OP_PUSH_FRONT,
      OP_PUSH_BACK,
      OP_POP_FRONT,
      OP_INSERT,
      OP_MARK,
      OP_REMOVE,
      OP_CLEAR
   } op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DEDUP,
      ST_SCAN
   } state_type;

   typedef struct packed {
      op_type             op;
      logic [VAL_W-1:0]   data;
   } cell_ctl_type;

   typedef struct packed {
      act_type            action;
      logic signed [VAL_W-1:0] value;
      logic [POS_W-1:0]   position;
   } req_type;

   typedef struct packed {
      logic signed [VAL_W-1:0] front_value;
      logic signed [VAL_W-1:0] back_value;
      logic signed [VAL_W-1:0] min_value;
      logic                    is_empty;
      logic [CNT_OUT_W-1:0]    entry_count;
      err_type                 error;
   } rsp_type;

endpackage

>>> src/bdq_cell.sv
// ---------------------------------------------------------------------------
// bdq_cell
// One deque slot: holds an entry and a duplicate mark, shifts with neighbors.
// ---------------------------------------------------------------------------
module bdq_cell #(
   parameter int CW    = 5,
   parameter int INDEX = 0
) (
   input  logic                       clock,
   input  bdq_pkg::cell_ctl_type      ctl,
   input  logic [CW-1:0]              cnt,
   input  logic [CW-1:0]              pt,
   input  logic [bdq_pkg::VAL_W-1:0]  left_val,
   input  logic [bdq_pkg::VAL_W-1:0]  right_val,
   input  logic                       right_dup,
   output logic [bdq_pkg::VAL_W-1:0]  val,
   output logic                       dup
);
   import bdq_pkg::*;

   localparam logic [CW-1:0] IDX = CW'(INDEX);

   logic [VAL_W-1:0] val_ff, val_in;
   logic             dup_ff, dup_in;

   always_comb begin
      val_in = val_ff;
      dup_in = dup_ff;
      unique case (ctl.op)
         OP_PUSH_FRONT: begin
            val_in = (IDX == '0) ? ctl.data : left_val;
            dup_in = 1'b0;
         end
         OP_PUSH_BACK: begin
            if (IDX == cnt) val_in = ctl.data;
         end
         OP_POP_FRONT: begin
            val_in = right_val;
            dup_in = right_dup;
         end
         OP_INSERT: begin
            if (IDX == pt) begin
               val_in = ctl.data;
            end else if (IDX > pt) begin
               val_in = left_val;
            end
         end
         OP_MARK: begin
            if (IDX > pt && val_ff == ctl.data) dup_in = 1'b1;
         end
         OP_REMOVE: begin
            if (IDX >= pt) begin
               val_in = right_val;
               dup_in = right_dup;
            end
         end
         OP_CLEAR: dup_in = 1'b0;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      val_ff <= val_in;
      dup_ff <= dup_in;
   end

   assign val = val_ff;
   assign dup = dup_ff;

endmodule

>>> src/bounded_deque_engine_top.sv
// Sequence: push/pop/insert/query scan every entry left after the action for the
// minimum before the result is registered; dedupe first runs its mark and remove
// steps over the entries present before it, then the same scan.
// Throughput: one request at a time; the min scan walks one cell per cycle.
// A finished result waits in an output register while the next request runs.
// Reset (synchronous, active high) empties the deque; cell contents stay undefined.
// ---------------------------------------------------------------------------
// bounded_deque_engine_top
// Bounded deque built from a chain of shifting cells with a sequencer.
// ---------------------------------------------------------------------------
`include "bounded_deque_engine_top_defines.svh"

module bounded_deque_engine_top #(
   parameter int DEPTH = bdq_pkg::DEPTH_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  bdq_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output bdq_pkg::rsp_type  rsp_data
);
   import bdq_pkg::*;

   localparam int CW = $clog2(DEPTH + 1);
   localparam int AW = $clog2(DEPTH);
   localparam int PW = (CW > POS_W) ? CW : POS_W;
   localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

   state_type        state_ff, state_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic [CW-1:0]    cur_ff, cur_in;
   logic [VAL_W-1:0] min_ff, min_in;
   err_type          err_ff, err_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_ff, rsp_in;

   cell_ctl_type     ctl;
   logic [CW-1:0]    pt;
   logic [VAL_W-1:0] vals [DEPTH];
   logic             dups [DEPTH];

   logic             acc, last, full, empty;
   logic [CW-1:0]    cnt_m1;
   logic [VAL_W-1:0] cur_val, step_min;
   logic             cur_dup;
   logic [PW-1:0]    pos_w, cnt_w;

   for (genvar g = 0; g < DEPTH; g++) begin : g_cell
      logic [VAL_W-1:0] lv, rv;
      logic             rd;
      if (g == 0) begin : g_first
         assign lv = '0;
      end else begin : g_mid
         assign lv = vals[g-1];
      end
      if (g == DEPTH - 1) begin : g_last
         assign rv = '0;
         assign rd = 1'b0;
      end else begin : g_inner
         assign rv = vals[g+1];
         assign rd = dups[g+1];
      end
      bdq_cell #(.CW(CW), .INDEX(g)) u_cell (
         .clock     (clock),
         .ctl       (ctl),
         .cnt       (cnt_ff),
         .pt        (pt),
         .left_val  (lv),
         .right_val (rv),
         .right_dup (rd),
         .val       (vals[g]),
         .dup       (dups[g])
      );
   end

   assign acc       = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign full      = (cnt_ff == FULL_CNT);
   assign empty     = (cnt_ff == '0);
   assign cnt_m1    = cnt_ff - CW'(1);
   assign cur_val   = vals[cur_ff[AW-1:0]];
   assign cur_dup   = dups[cur_ff[AW-1:0]];
   assign last      = empty || (cur_ff == cnt_m1);
   assign pos_w     = PW'(req_data.position);
   assign cnt_w     = PW'(cnt_ff);

   always_comb begin
      if (empty) begin
         step_min = '1;
      end else if (cur_ff == '0 || $signed(cur_val) < $signed(min_ff)) begin
         step_min = cur_val;
      end else begin
         step_min = min_ff;
      end
   end

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      cur_in       = cur_ff;
      min_in       = min_ff;
      err_in       = err_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      ctl.op       = OP_NONE;
      ctl.data     = req_data.value;
      pt           = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (acc) begin
               err_in   = ERR_OK;
               cur_in   = '0;
               state_in = ST_SCAN;
               unique case (req_data.action)
                  ACT_PUSH_FRONT: begin
                     if (full) begin
                        err_in = ERR_FULL;
                     end else begin
                        ctl.op = OP_PUSH_FRONT;
                        cnt_in = cnt_ff + CW'(1);
                     end
                  end
                  ACT_PUSH_BACK: begin
                     if (full) begin
                        err_in = ERR_FULL;
                     end else begin
                        ctl.op = OP_PUSH_BACK;
                        cnt_in = cnt_ff + CW'(1);
                     end
                  end
                  ACT_POP_FRONT: begin
                     if (empty) begin
                        err_in = ERR_EMPTY;
                     end else begin
                        ctl.op = OP_POP_FRONT;
                        cnt_in = cnt_m1;
                     end
                  end
                  ACT_POP_BACK: begin
                     if (empty) begin
                        err_in = ERR_EMPTY;
                     end else begin
                        cnt_in = cnt_m1;
                     end
                  end
                  ACT_INSERT: begin
                     if (full) begin
                        err_in = ERR_FULL;
                     end else if (pos_w == '0 || pos_w > cnt_w) begin
                        err_in = ERR_POS;
                     end else begin
                        ctl.op = OP_INSERT;
                        pt     = pos_w[CW-1:0];
                        cnt_in = cnt_ff + CW'(1);
                     end
                  end
                  ACT_DEDUPE: begin
                     ctl.op   = OP_CLEAR;
                     state_in = ST_DEDUP;
                  end
                  default: ;
               endcase
            end
         end
         ST_DEDUP: begin
            pt = cur_ff;
            if (cur_ff >= cnt_ff) begin
               cur_in   = '0;
               state_in = ST_SCAN;
            end else if (cur_dup) begin
               ctl.op = OP_REMOVE;
               cnt_in = cnt_m1;
            end else begin
               ctl.op   = OP_MARK;
               ctl.data = cur_val;
               cur_in   = cur_ff + CW'(1);
            end
         end
         ST_SCAN: begin
            min_in = step_min;
            if (!last) begin
               cur_in = cur_ff + CW'(1);
            end else if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in        = 1'b1;
               rsp_in.front_value  = empty ? '0 : vals[0];
               rsp_in.back_value   = empty ? '0 : vals[cnt_m1[AW-1:0]];
               rsp_in.min_value    = step_min;
               rsp_in.is_empty     = empty;
               rsp_in.entry_count  = CNT_OUT_W'(cnt_ff);
               rsp_in.error        = err_ff;
               state_in            = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         cur_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         cur_ff       <= cur_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      min_ff <= min_in;
      err_ff <= err_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `BDQ_ASSERT_ALWAYS(a_cnt_bound, cnt_ff <= FULL_CNT)
   `BDQ_ASSERT_NEXT(a_acc_busy, acc, state_ff != ST_IDLE)
   `BDQ_ASSERT_NEXT(a_dedup_shrinks, state_ff == ST_DEDUP, cnt_ff <= $past(cnt_ff))
   `BDQ_ASSERT_SAME(a_scan_cursor, state_ff == ST_SCAN, empty || cur_ff < cnt_ff)

endmodule
